// ===== hw/rtl/lifegrid_pkg.sv =====
// lifegrid_pkg: item types and command and status codes of the life grid unit
// no dependencies; used by life_cellular_automaton_grid_unit

package lifegrid_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_EVOLVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        cell_value;
        logic [15:0] gen_count;
    } t_in_item;

    typedef struct packed {
        logic       cell_alive;
        logic [3:0] neighbor_count;
        logic       status;
    } t_out_item;

endpackage

// ===== hw/rtl/lifegrid_ram.sv =====
// lifegrid_ram: generic single write port, single read port ram with registered read
// no dependencies

module lifegrid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/lifegrid_row_unit.sv =====
// lifegrid_row_unit: neighbor counts and next generation of one grid row
// from the row above, the row itself and the row below; no dependencies

module lifegrid_row_unit #(
    parameter int COLS = 16
) (
    input  logic [COLS-1:0]       i_above,
    input  logic [COLS-1:0]       i_mid,
    input  logic [COLS-1:0]       i_below,
    output logic [COLS-1:0]       o_next,
    output logic [COLS-1:0][3:0]  o_count
);

    logic [COLS+1:0] pad_above;
    logic [COLS+1:0] pad_mid;
    logic [COLS+1:0] pad_below;

    // cells beyond the left and right edges are dead
    assign pad_above = {1'b0, i_above, 1'b0};
    assign pad_mid   = {1'b0, i_mid, 1'b0};
    assign pad_below = {1'b0, i_below, 1'b0};

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            o_count[c] = {3'b000, pad_above[c]} + {3'b000, pad_above[c+1]}
                       + {3'b000, pad_above[c+2]} + {3'b000, pad_mid[c]}
                       + {3'b000, pad_mid[c+2]} + {3'b000, pad_below[c]}
                       + {3'b000, pad_below[c+1]} + {3'b000, pad_below[c+2]};
            o_next[c] = (o_count[c] == 4'd3) || (i_mid[c] && (o_count[c] == 4'd2));
        end
    end

endmodule

// ===== hw/rtl/life_cellular_automaton_grid_unit.sv =====
// life_cellular_automaton_grid_unit: bounded life grid with write, evolve and query
// depends on lifegrid_pkg, lifegrid_ram and lifegrid_row_unit

// The grid is GRID_ROWS rows of GRID_COLS cells, one ram word per row, all dead
// after reset (a per-row valid flag masks rows never written, so no clearing pass).
// Items are taken one at a time; ready is low while an item is at work. A write
// reads the row, modifies it and writes it back, then loads the output; a query
// reads three rows into a window, counts, then loads the output; an item that is
// out of range, an unused command or an evolve of zero generations goes straight
// to the output load. An evolve runs g generations, each a pass over all rows: the
// single ram read port brings in one row per cycle and the shared row unit updates
// the row behind it in place. Evolution stops early after a generation that leaves the grid unchanged.

module life_cellular_automaton_grid_unit #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lifegrid_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lifegrid_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int KW = $clog2(GRID_ROWS + 1);
    localparam logic [6:0]  ROW_LIMIT = 7'(GRID_ROWS);
    localparam logic [6:0]  COL_LIMIT = 7'(GRID_COLS);
    localparam logic [KW:0] K_LAST    = (KW + 1)'(GRID_ROWS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WR   = 7'b0000010,
        S_Q1   = 7'b0000100,
        S_Q2   = 7'b0001000,
        S_Q3   = 7'b0010000,
        S_EV   = 7'b0100000,
        S_PUSH = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_row;
    logic [CW-1:0]           r_col;
    logic                    r_value;
    logic [15:0]             r_gens, n_gens;
    logic [KW-1:0]           r_k, n_k;
    logic [GRID_COLS-1:0]    r_prev, n_prev;
    logic [GRID_COLS-1:0]    r_cur, n_cur;
    logic                    r_rd_ok;
    logic                    r_changed, n_changed;
    lifegrid_pkg::t_out_item r_res, n_res;
    logic                    r_out_valid;
    lifegrid_pkg::t_out_item r_out_item;
    logic [GRID_ROWS-1:0]    r_row_valid;

    logic                    accept;
    logic                    in_inside;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [GRID_COLS-1:0]    wdata;
    logic [GRID_COLS-1:0]    ram_q;
    logic [GRID_COLS-1:0]    rd_data;
    logic [GRID_COLS-1:0]    unit_next;
    logic [GRID_COLS-1:0][3:0] unit_count;
    logic                    out_free;
    logic [KW:0]             k_plus;
    logic [AW:0]             row_plus;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_inside  = ({1'b0, i_in_item.row} < ROW_LIMIT)
                     && ({1'b0, i_in_item.col} < COL_LIMIT);
    // rows past the bottom edge or never written read as dead
    assign rd_data    = ram_q & {GRID_COLS{r_rd_ok}};
    assign k_plus     = {1'b0, r_k} + (KW + 1)'(1);
    assign row_plus   = {1'b0, r_row} + (AW + 1)'(1);

    lifegrid_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    lifegrid_row_unit #(
        .COLS (GRID_COLS)
    ) u_row_unit (
        .i_above (r_prev),
        .i_mid   (r_cur),
        .i_below (rd_data),
        .o_next  (unit_next),
        .o_count (unit_count)
    );

    always_comb begin
        n_state   = r_state;
        n_gens    = r_gens;
        n_k       = r_k;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_changed = r_changed;
        n_res     = r_res;
        rd_en     = 1'b0;
        rd_addr   = '0;
        we        = 1'b0;
        waddr     = r_row;
        wdata     = rd_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_PUSH;
                    case (i_in_item.command)
                        lifegrid_pkg::CMD_WRITE: begin
                            if (in_inside) begin
                                rd_en   = 1'b1;
                                rd_addr = i_in_item.row[AW-1:0];
                                n_state = S_WR;
                            end else begin
                                n_res.status = lifegrid_pkg::STATUS_OUTSIDE;
                            end
                        end
                        lifegrid_pkg::CMD_EVOLVE: begin
                            if (i_in_item.gen_count != 16'd0) begin
                                rd_en     = 1'b1;
                                rd_addr   = '0;
                                n_gens    = i_in_item.gen_count;
                                n_k       = '0;
                                n_prev    = '0;
                                n_cur     = '0;
                                n_changed = 1'b0;
                                n_state   = S_EV;
                            end
                        end
                        lifegrid_pkg::CMD_QUERY: begin
                            if (in_inside) begin
                                // row above, none on the top edge
                                rd_en   = (i_in_item.row != 6'd0);
                                rd_addr = i_in_item.row[AW-1:0] - AW'(1);
                                n_state = S_Q1;
                            end else begin
                                n_res.status = lifegrid_pkg::STATUS_OUTSIDE;
                            end
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_WR: begin
                we             = 1'b1;
                waddr          = r_row;
                wdata          = rd_data;
                wdata[r_col]   = r_value;
                n_state        = S_PUSH;
            end
            S_Q1: begin
                n_prev  = r_cur;
                n_cur   = rd_data;
                rd_en   = 1'b1;
                rd_addr = r_row;
                n_state = S_Q2;
            end
            S_Q2: begin
                n_prev  = r_cur;
                n_cur   = rd_data;
                rd_en   = (row_plus < (AW + 1)'(GRID_ROWS));
                rd_addr = row_plus[AW-1:0];
                n_state = S_Q3;
            end
            S_Q3: begin
                n_res.cell_alive     = r_cur[r_col];
                n_res.neighbor_count = unit_count[r_col];
                n_res.status         = lifegrid_pkg::STATUS_DONE;
                n_state              = S_PUSH;
            end
            S_EV: begin
                // window holds rows k-2 and k-1, ram output row k; row k-1 is rewritten
                n_prev = r_cur;
                n_cur  = rd_data;
                if (k_plus < K_LAST) begin
                    rd_en   = 1'b1;
                    rd_addr = k_plus[AW-1:0];
                end
                if (r_k != '0) begin
                    we        = 1'b1;
                    waddr     = AW'(r_k - KW'(1));
                    wdata     = unit_next;
                    n_changed = r_changed || (unit_next != r_cur);
                end
                n_k = k_plus[KW-1:0];
                if ({1'b0, r_k} == K_LAST) begin
                    if ((r_gens == 16'd1) || !n_changed) begin
                        n_state = S_PUSH;
                    end else begin
                        n_gens    = r_gens - 16'd1;
                        n_k       = '0;
                        n_prev    = '0;
                        n_cur     = '0;
                        n_changed = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                    end
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state <= n_state;
            r_rd_ok <= rd_en && r_row_valid[rd_addr];
            if (we) begin
                r_row_valid[waddr] <= 1'b1;
            end
            if ((r_state == S_PUSH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row   <= i_in_item.row[AW-1:0];
            r_col   <= i_in_item.col[CW-1:0];
            r_value <= i_in_item.cell_value;
        end
        r_gens    <= n_gens;
        r_k       <= n_k;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_changed <= n_changed;
        r_res     <= n_res;
        if ((r_state == S_PUSH) && out_free) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
